// File: hw/rtl/point_glow_wave_shader_top_macros.svh
// Assertion macros for the point glow and wave shader.
// Used by the top level only; needs nothing else.
`ifndef POINT_GLOW_WAVE_SHADER_TOP_MACROS_SVH
`define POINT_GLOW_WAVE_SHADER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGWS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PGWS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pgws_pkg.sv
// Shared constants, types and the cosine table of the point glow and wave shader.
// Used by the square root unit, the divider and the top level.
package pgws_pkg;

  localparam int FRAC_BITS       = 8;
  localparam int COS_TABLE_DEPTH = 256;
  localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
  localparam int ROM_AW          = COS_IDX_W + 1;
  localparam int PHASE_W         = 20;

  // Datapath widths of the square root and divider units.
  localparam int SQ_IN_W     = 57;
  localparam int ROOT_W      = 29;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_NUM_W   = 47;
  localparam int DIV_DEN_W   = 27;
  localparam int DIV_STAGES  = PHASE_W;

  // Point size scale: 4.0 and 2.0 in the size format.
  localparam int SIZE_FULL_SH = FRAC_BITS + 2;
  localparam int SIZE_HALF_SH = FRAC_BITS + 1;
  localparam int SIZE_FULL    = 1 << SIZE_FULL_SH;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GLOW_X        = 3'd0,
    CFG_GLOW_Y        = 3'd1,
    CFG_GLOW_RADIUS   = 3'd2,
    CFG_GLOW_STRENGTH = 3'd3,
    CFG_WAVE_RADIUS   = 3'd4,
    CFG_WAVE_STRENGTH = 3'd5,
    CFG_OUTER_RADIUS  = 3'd6
  } cfg_idx_e;

  typedef logic [31:0] cos_rom_t [COS_TABLE_DEPTH+1];

  // Q2.30 cosine samples over a quarter turn, each an 8-term Taylor series.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned inner;
    longint unsigned t;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      x = HALF_PI_Q30 * 64'(i) / COS_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      inner = ONE_Q30;
      t = ((x2 * inner) >> 30) / 182;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 132;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 90;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 56;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 30;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 12;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t = ((x2 * inner) >> 30) / 2;
      inner = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      rom[i] = 32'(inner);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// File: hw/rtl/point_glow_wave_shader_top.sv
// Point glow and wave shader: throughput one point per cycle while the output
// register is not holding an untaken result, set by the fully pipelined square
// root (29 stages) and dividers (20 stages).
// The whole pipeline stalls while the output register holds an untaken result.
// Points whose alpha is zero are dropped. Reset (async, active low) clears the
// valid bits and the configuration registers; wave_radius resets to 50.0.
// Depends on pgws_pkg, pgws_sqrt, pgws_div and the assertion macro header.
`include "point_glow_wave_shader_top_macros.svh"

module point_glow_wave_shader_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // point_x[19:0], point_y[39:20], band_radius[58:40]
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // out_x[19:0], out_y[39:20], point_size[50:40],
                                     // alpha[58:51]
);
  import pgws_pkg::*;

  localparam int LANES     = 2;
  localparam int LANE_GLOW = 0;
  localparam int LANE_WAVE = 1;

  // Register stage numbers along the pipeline.
  localparam int S_IN   = 1;
  localparam int S_SUM  = 3;
  localparam int S_ROOT = S_SUM + SQRT_STAGES;
  localparam int S_NUM  = S_ROOT + 1;
  localparam int S_PH   = S_NUM + DIV_STAGES;
  localparam int S_ROM  = S_PH + 1;
  localparam int S_C10  = S_ROM + 6;
  localparam int S_STR  = S_C10 + 1;

  // Configuration registers.
  logic [19:0] glow_x_q, glow_y_q;
  logic [18:0] glow_r_q, wave_r_q, outer_r_q;
  logic [8:0]  glow_str_q, wave_str_q;
  logic [37:0] glow_rsq_q;
  logic [39:0] wave_lim_q;

  logic adv;
  logic [S_STR:S_IN] vld_q;
  logic out_vld_q;

  // Pipeline payload.
  logic [39:0] pxy_q  [S_IN:S_STR];
  logic [18:0] band_q [S_IN:S_ROOT];
  logic [LANES-1:0] hit_q [S_SUM:S_C10];
  logic        sp_q   [S_NUM:S_PH];
  logic [10:0] spv_q  [S_NUM:S_PH];
  logic [10:0] size_q [S_ROM:S_STR];

  logic [19:0] in_px, in_py;
  logic [18:0] in_band;
  logic [19:0] cx [LANES];
  logic [19:0] cy [LANES];
  logic [19:0] ax_d [LANES];
  logic [19:0] ay_d [LANES];
  logic [19:0] ax_q [LANES];
  logic [19:0] ay_q [LANES];
  logic [39:0] sqx_q [LANES];
  logic [39:0] sqy_q [LANES];
  logic [40:0] sum_q [LANES];
  logic [ROOT_W-1:0] root [LANES];
  logic [DIV_NUM_W-1:0] num_q [LANES];
  logic [DIV_DEN_W-1:0] den_q [LANES];
  logic [PHASE_W-1:0]   quo [LANES];
  logic [DIV_NUM_W-1:0] num_s_q;
  logic [DIV_DEN_W-1:0] den_s_q;
  logic [PHASE_W-1:0]   quo_s;
  logic [31:0] rom_a_q [LANES];
  logic [31:0] rom_b_q [LANES];
  logic [PHASE_W-1:0] frac_q [LANES];
  logic [31:0] a2_q [LANES];
  logic [51:0] prod_q [LANES];
  logic [30:0] c_q [LANES];
  logic [30:0] c2_q [LANES];
  logic [30:0] c2d_q [LANES];
  logic [30:0] c2e_q [LANES];
  logic [30:0] c4_q [LANES];
  logic [30:0] p59_q [LANES];
  logic [30:0] p60_q [LANES];
  logic [39:0] term_q [LANES];
  logic [39:0] oxy_q;
  logic [10:0] size_out_q;
  logic [7:0]  alpha_q;

  logic [28:0] wdist;
  logic [DIV_DEN_W-1:0] wr;
  logic        sp_d;
  logic [10:0] spv_d;
  logic [PHASE_W-1:0] size_quo;
  logic [39:0] best;
  logic [47:0] best255;
  logic [9:0]  alpha_w;
  logic [7:0]  alpha_d;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign in_px   = s_axis_tdata[19:0];
  assign in_py   = s_axis_tdata[39:20];
  assign in_band = s_axis_tdata[58:40];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_x_q   <= '0;
      glow_y_q   <= '0;
      glow_r_q   <= '0;
      glow_str_q <= '0;
      wave_r_q   <= 19'd12800;
      wave_str_q <= '0;
      outer_r_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GLOW_X:        glow_x_q   <= cfg_data_i;
        CFG_GLOW_Y:        glow_y_q   <= cfg_data_i;
        CFG_GLOW_RADIUS:   glow_r_q   <= cfg_data_i[18:0];
        CFG_GLOW_STRENGTH: glow_str_q <= cfg_data_i[8:0];
        CFG_WAVE_RADIUS:   wave_r_q   <= cfg_data_i[18:0];
        CFG_WAVE_STRENGTH: wave_str_q <= cfg_data_i[8:0];
        CFG_OUTER_RADIUS:  outer_r_q  <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  // Squared limits, updated from the configuration every cycle.
  always_ff @(posedge clk_i) begin
    glow_rsq_q <= {19'd0, glow_r_q} * {19'd0, glow_r_q};
    wave_lim_q <= {({19'd0, wave_r_q} * {19'd0, wave_r_q}), 2'b00};
  end

  // Valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[S_STR-1:S_IN], s_axis_tvalid};
      out_vld_q <= vld_q[S_STR] && (alpha_d != 8'd0);
    end
  end

  // Absolute offsets from the glow centre and from the origin.
  assign cx[LANE_GLOW] = glow_x_q;
  assign cy[LANE_GLOW] = glow_y_q;
  assign cx[LANE_WAVE] = '0;
  assign cy[LANE_WAVE] = '0;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [20:0] dx;
      logic [20:0] dy;
      dx = {in_px[19], in_px} - {cx[l][19], cx[l]};
      dy = {in_py[19], in_py} - {cy[l][19], cy[l]};
      ax_d[l] = dx[20] ? 20'(21'd0 - dx) : dx[19:0];
      ay_d[l] = dy[20] ? 20'(21'd0 - dy) : dy[19:0];
    end
  end

  // Front end: offsets, squares, sums and range tests.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        ax_q[l]  <= ax_d[l];
        ay_q[l]  <= ay_d[l];
        sqx_q[l] <= {20'd0, ax_q[l]} * {20'd0, ax_q[l]};
        sqy_q[l] <= {20'd0, ay_q[l]} * {20'd0, ay_q[l]};
        sum_q[l] <= {1'b0, sqx_q[l]} + {1'b0, sqy_q[l]};
      end
      hit_q[S_SUM][LANE_GLOW] <= ({1'b0, sqx_q[LANE_GLOW]} + {1'b0, sqy_q[LANE_GLOW]})
                                 < 41'(glow_rsq_q);
      hit_q[S_SUM][LANE_WAVE] <= ({1'b0, sqx_q[LANE_WAVE]} + {1'b0, sqy_q[LANE_WAVE]})
                                 < 41'(wave_lim_q);
      for (int k = S_SUM + 1; k <= S_C10; k++) hit_q[k] <= hit_q[k-1];
    end
  end

  // Delay lines for the pass-through fields.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxy_q[S_IN]  <= {in_py, in_px};
      band_q[S_IN] <= in_band;
      for (int k = S_IN + 1; k <= S_STR; k++) pxy_q[k] <= pxy_q[k-1];
      for (int k = S_IN + 1; k <= S_ROOT; k++) band_q[k] <= band_q[k-1];
    end
  end

  // Distances, one square root per lane.
  for (genvar l = 0; l < LANES; l++) begin : g_sqrt
    pgws_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  ({sum_q[l], 16'd0}),
      .root_o (root[l])
    );
  end

  // Dividend and divisor of each phase and of the point size.
  assign wr    = {wave_r_q, 8'd0};
  assign wdist = (root[LANE_WAVE] >= 29'(wr)) ? root[LANE_WAVE] - 29'(wr)
                                               : 29'(wr) - root[LANE_WAVE];

  always_comb begin
    sp_d  = 1'b0;
    spv_d = '0;
    if (outer_r_q == 19'd0) begin
      sp_d  = 1'b1;
      spv_d = (band_q[S_ROOT] == 19'd0) ? 11'(SIZE_FULL) : 11'd0;
    end else if ({1'b0, band_q[S_ROOT]} >= {outer_r_q, 1'b0}) begin
      sp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[LANE_GLOW] <= {root[LANE_GLOW][27:0], 19'd0};
      den_q[LANE_GLOW] <= {glow_r_q, 8'd0};
      num_q[LANE_WAVE] <= {wdist[26:0], 20'd0};
      den_q[LANE_WAVE] <= wr;
      num_s_q <= DIV_NUM_W'(({11'd0, outer_r_q} << SIZE_FULL_SH)
                            - ({11'd0, band_q[S_ROOT]} << SIZE_HALF_SH));
      den_s_q <= DIV_DEN_W'(outer_r_q);
      sp_q[S_NUM]  <= sp_d;
      spv_q[S_NUM] <= spv_d;
      for (int k = S_NUM + 1; k <= S_PH; k++) begin
        sp_q[k]  <= sp_q[k-1];
        spv_q[k] <= spv_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_div
    pgws_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[l]),
      .den_i (den_q[l]),
      .quo_o (quo[l])
    );
  end

  pgws_div u_div_size (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_s_q),
    .den_i (den_s_q),
    .quo_o (quo_s)
  );

  assign size_quo = (quo_s > PHASE_W'(SIZE_FULL)) ? PHASE_W'(SIZE_FULL) : quo_s;

  // Cosine by table and interpolation, then the powers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      size_q[S_ROM] <= sp_q[S_PH] ? spv_q[S_PH] : size_quo[10:0];
      for (int k = S_ROM + 1; k <= S_STR; k++) size_q[k] <= size_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        logic [ROM_AW-1:0] idx;
        logic [31:0]       dif;
        logic [61:0]       p;
        idx = {1'b0, quo[l][PHASE_W-1 -: COS_IDX_W]};
        // Table read.
        rom_a_q[l] <= COS_ROM[idx];
        rom_b_q[l] <= COS_ROM[idx + ROM_AW'(1)];
        frac_q[l]  <= quo[l] << COS_IDX_W;
        // Interpolation product.
        dif = (rom_a_q[l] >= rom_b_q[l]) ? rom_a_q[l] - rom_b_q[l] : 32'd0;
        prod_q[l] <= {20'd0, dif} * {32'd0, frac_q[l]};
        a2_q[l]   <= rom_a_q[l];
        c_q[l]    <= 31'(a2_q[l] - prod_q[l][51:20]);
        // Squarings in Q30.
        p = {31'd0, c_q[l]} * {31'd0, c_q[l]};
        c2_q[l] <= p[60:30];
        p = {31'd0, c2_q[l]} * {31'd0, c2_q[l]};
        c4_q[l]  <= p[60:30];
        c2d_q[l] <= c2_q[l];
        p = {31'd0, c4_q[l]} * {31'd0, (l == LANE_GLOW) ? c4_q[l] : c2d_q[l]};
        p59_q[l] <= p[60:30];
        c2e_q[l] <= c2d_q[l];
        p = {31'd0, p59_q[l]} * {31'd0, c2e_q[l]};
        p60_q[l] <= (l == LANE_GLOW) ? p[60:30] : p59_q[l];
      end
      term_q[LANE_GLOW] <= hit_q[S_C10][LANE_GLOW]
                           ? {31'd0, glow_str_q} * {9'd0, p60_q[LANE_GLOW]} : 40'd0;
      term_q[LANE_WAVE] <= hit_q[S_C10][LANE_WAVE]
                           ? {31'd0, wave_str_q} * {9'd0, p60_q[LANE_WAVE]} : 40'd0;
    end
  end

  // Alpha from the stronger term, saturated to eight bits.
  assign best    = (term_q[LANE_GLOW] > term_q[LANE_WAVE]) ? term_q[LANE_GLOW]
                                                          : term_q[LANE_WAVE];
  assign best255 = {best, 8'd0} - {8'd0, best};
  assign alpha_w = best255[47:38];
  assign alpha_d = (alpha_w > 10'd255) ? 8'd255 : alpha_w[7:0];

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      oxy_q      <= pxy_q[S_STR];
      size_out_q <= size_q[S_STR];
      alpha_q    <= alpha_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, alpha_q, size_out_q, oxy_q};

  `PGWS_ASSERT_IMP(a_alpha_nonzero, clk_i, rst_ni, out_vld_q, alpha_q != 8'd0, "zero alpha sent")
  `PGWS_ASSERT_IMP(a_size_range, clk_i, rst_ni, out_vld_q, size_out_q <= 11'(SIZE_FULL), "size over 4.0")
  `PGWS_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, !adv, $stable(vld_q), "pipeline moved while stalled")
  `PGWS_ASSERT_IMP(a_out_source, clk_i, rst_ni, $rose(out_vld_q), $past(vld_q[S_STR]), "result without item")

endmodule

// File: hw/rtl/pgws_sqrt.sv
// Pipelined integer square root, one result bit per stage, floored.
// Depends on pgws_pkg for its widths.
module pgws_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pgws_pkg::SQ_IN_W-1:0] rad_i,
  output logic [pgws_pkg::ROOT_W-1:0]  root_o
);
  import pgws_pkg::*;

  logic [SQ_IN_W-1:0] rem_q  [SQRT_STAGES-1];
  logic [ROOT_W-1:0]  root_q [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - j;
    logic [SQ_IN_W-1:0] rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [SQ_IN_W:0]   trial;
    logic               take;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // Setting bit K adds 2*root*2^K + 2^2K to the square.
    assign trial = ((SQ_IN_W+1)'(root_in) << (K + 1)) | ((SQ_IN_W+1)'(1) << (2 * K));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
      end
    end

    if (j < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_in - trial[SQ_IN_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// File: hw/rtl/pgws_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in DIV_STAGES bits. Depends on pgws_pkg.
module pgws_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pgws_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [pgws_pkg::DIV_DEN_W-1:0] den_i,
  output logic [pgws_pkg::PHASE_W-1:0]   quo_o
);
  import pgws_pkg::*;

  logic [DIV_NUM_W-1:0] rem_q [DIV_STAGES-1];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES-1];
  logic [PHASE_W-1:0]   quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - j;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [PHASE_W-1:0]   quo_in;
    logic [DIV_NUM_W-1:0] dsh;
    logic                 take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Try to take the divisor shifted to this quotient bit.
    assign dsh  = DIV_NUM_W'(den_in) << B;
    assign take = rem_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= take ? (quo_in | (PHASE_W'(1) << B)) : quo_in;
      end
    end

    if (j < DIV_STAGES - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_in - dsh) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule
